FILE: rtl/dacs_pkg.sv
// ----------------------------------------------------------------------------
// dacs_pkg
// Types and constants shared by the dual ADC capture supervisor.
// ----------------------------------------------------------------------------
`default_nettype none

package dacs_pkg;

	localparam int unsigned CFG_W      = 31;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned RAW_W      = 16;
	localparam int unsigned VALUE_W    = 12;

	localparam logic [CFG_W-1:0] DEADLINE_RESET  = 31'd3;
	localparam logic [CFG_W-1:0] SPACING_RESET   = 31'd5;
	localparam logic [CFG_W-1:0] MIN_DEADLINE_US = 31'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 1'b1;

	typedef enum logic [1:0] {
		FN_INIT     = 2'd0,
		FN_ARM      = 2'd1,
		FN_TAKE     = 2'd2,
		FN_SHUTDOWN = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_OFF        = 4'd0,
		ST_WARMING    = 4'd1,
		ST_IDLE       = 4'd2,
		ST_PENDING    = 4'd3,
		ST_BADCFG     = 4'd4,
		ST_TIMEOUT    = 4'd5,
		ST_CFGCHG     = 4'd6,
		ST_UNEXPECTED = 4'd7,
		ST_BADDATA    = 4'd8,
		ST_BUSY       = 4'd9,
		ST_READY      = 4'd10
	} status_t;

	typedef enum logic [8:0] {
		MD_OFF        = 9'b000000001,
		MD_WARMING    = 9'b000000010,
		MD_IDLE       = 9'b000000100,
		MD_PENDING    = 9'b000001000,
		MD_BADCFG     = 9'b000010000,
		MD_TIMEOUT    = 9'b000100000,
		MD_CFGCHG     = 9'b001000000,
		MD_UNEXPECTED = 9'b010000000,
		MD_BADDATA    = 9'b100000000
	} mode_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_latency_us;
		logic [CFG_W-1:0] trigger_spacing_us;
	} cfg_t;

	typedef struct packed {
		func_t             func;
		logic [TIME_W-1:0] now_us;
		logic              setup_intact;
		logic              hw_in_use;
		logic              b_started;
		logic              b_done;
		logic              b_stray;
		logic              c_started;
		logic              c_done;
		logic              c_stray;
		logic [RAW_W-1:0]  b_sample;
		logic [RAW_W-1:0]  c_sample;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic               frame_valid;
		logic [VALUE_W-1:0] b_value;
		logic [VALUE_W-1:0] c_value;
		logic [TIME_W-1:0]  arm_time_us;
		logic [TIME_W-1:0]  done_time_us;
		logic               b_trigger_enable;
		logic               c_trigger_enable;
	} res_t;

	function automatic status_t mode_status(mode_t m);
		status_t s;
		unique case (m)
			MD_OFF:        s = ST_OFF;
			MD_WARMING:    s = ST_WARMING;
			MD_IDLE:       s = ST_IDLE;
			MD_PENDING:    s = ST_PENDING;
			MD_BADCFG:     s = ST_BADCFG;
			MD_TIMEOUT:    s = ST_TIMEOUT;
			MD_CFGCHG:     s = ST_CFGCHG;
			MD_UNEXPECTED: s = ST_UNEXPECTED;
			MD_BADDATA:    s = ST_BADDATA;
			default:       s = ST_OFF;
		endcase
		return s;
	endfunction

	function automatic logic mode_faulted(mode_t m);
		return (m == MD_BADCFG) || (m == MD_TIMEOUT) || (m == MD_CFGCHG) ||
			(m == MD_UNEXPECTED) || (m == MD_BADDATA);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/dacs_if.sv
// ----------------------------------------------------------------------------
// dacs_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface dacs_cmd_if import dacs_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface dacs_res_if import dacs_pkg::*; ();
	logic valid;
	logic ready;
	res_t item;

	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

`default_nettype wire

FILE: rtl/dacs_cfg_regs.sv
// ----------------------------------------------------------------------------
// dacs_cfg_regs
// Deadline and trigger spacing registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dacs_cfg_regs import dacs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_latency_us     <= DEADLINE_RESET;
			cfg_q.trigger_spacing_us <= SPACING_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DEADLINE: cfg_q.max_latency_us     <= cfg_wdata;
				CFG_SPACING:  cfg_q.trigger_spacing_us <= cfg_wdata;
				default:      cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/dacs_engine.sv
// ----------------------------------------------------------------------------
// dacs_engine
// Supervisor state and the combinational decision for one command item.
// ----------------------------------------------------------------------------
`default_nettype none

module dacs_engine import dacs_pkg::*; #(
	parameter int unsigned WARMUP_US   = 10,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  var cfg_t  cfg,
	input  var cmd_t  cmd,
	output res_t      res
);

	mode_t             mode_q, mode_n;
	logic [TIME_W-1:0] enable_time_q, enable_time_n;
	logic [TIME_W-1:0] arm_time_q, arm_time_n;
	logic [CFG_W-1:0]  held_deadline_q, held_deadline_n;
	logic [1:0]        done_mask_q, done_mask_n;
	logic [1:0]        trig_q, trig_n;

	logic [TIME_W-1:0] age;
	logic [TIME_W-1:0] elapsed;
	logic              cfg_bad;
	logic              any_flag;
	logic              stray;
	logic              b_over;
	logic              c_over;
	logic              fault;
	mode_t             fault_code;
	status_t           status;
	logic              frame;

	always_comb begin
		age      = cmd.now_us - enable_time_q;
		elapsed  = cmd.now_us - arm_time_q;
		cfg_bad  = (cfg.max_latency_us < MIN_DEADLINE_US) ||
			(({1'b0, cfg.max_latency_us} + 32'd1) >= {1'b0, cfg.trigger_spacing_us});
		any_flag = cmd.b_started | cmd.b_done | cmd.b_stray |
			cmd.c_started | cmd.c_done | cmd.c_stray;
		stray    = cmd.b_stray | cmd.c_stray | (cmd.b_done & ~cmd.b_started) |
			(cmd.c_done & ~cmd.c_started);
		b_over   = (cmd.b_sample >> SAMPLE_BITS) != '0;
		c_over   = (cmd.c_sample >> SAMPLE_BITS) != '0;
	end

	always_comb begin
		mode_n          = mode_q;
		enable_time_n   = enable_time_q;
		arm_time_n      = arm_time_q;
		held_deadline_n = held_deadline_q;
		done_mask_n     = done_mask_q;
		trig_n          = trig_q;
		fault           = 1'b0;
		fault_code      = MD_CFGCHG;
		frame           = 1'b0;
		status          = mode_status(mode_q);

		unique case (cmd.func)
			FN_INIT: begin
				if (mode_q != MD_OFF) begin
					status = ST_BUSY;
				end else if (cfg_bad) begin
					status = ST_BADCFG;
				end else if (cmd.hw_in_use) begin
					status = ST_BUSY;
				end else begin
					enable_time_n   = cmd.now_us;
					held_deadline_n = cfg.max_latency_us;
					done_mask_n     = 2'b00;
					trig_n          = 2'b00;
					mode_n          = MD_WARMING;
					status          = ST_WARMING;
				end
			end
			FN_ARM: begin
				if (mode_q == MD_OFF || mode_faulted(mode_q)) begin
					status = mode_status(mode_q);
				end else if (mode_q == MD_PENDING) begin
					status = ST_BUSY;
				end else if (!cmd.setup_intact) begin
					fault      = 1'b1;
					fault_code = MD_CFGCHG;
				end else if (mode_q == MD_WARMING && age[TIME_W-1]) begin
					fault      = 1'b1;
					fault_code = MD_TIMEOUT;
				end else if (mode_q == MD_WARMING && age < TIME_W'(WARMUP_US)) begin
					status = ST_WARMING;
				end else if (any_flag) begin
					fault      = 1'b1;
					fault_code = MD_UNEXPECTED;
				end else begin
					done_mask_n = 2'b00;
					arm_time_n  = cmd.now_us;
					mode_n      = MD_PENDING;
					trig_n      = 2'b11;
					status      = ST_PENDING;
				end
			end
			FN_TAKE: begin
				if (mode_q != MD_PENDING) begin
					status = mode_status(mode_q);
				end else if (!cmd.setup_intact) begin
					fault      = 1'b1;
					fault_code = MD_CFGCHG;
				end else if (elapsed > {1'b0, held_deadline_q}) begin
					fault      = 1'b1;
					fault_code = MD_TIMEOUT;
				end else if (stray) begin
					fault      = 1'b1;
					fault_code = MD_UNEXPECTED;
				end else begin
					if (cmd.b_started && cmd.b_done) begin
						trig_n[0]      = 1'b0;
						done_mask_n[0] = 1'b1;
					end
					if (cmd.c_started && cmd.c_done) begin
						trig_n[1]      = 1'b0;
						done_mask_n[1] = 1'b1;
					end
					if (done_mask_n != 2'b11) begin
						status = ST_PENDING;
					end else if (!(cmd.b_started && cmd.b_done &&
						cmd.c_started && cmd.c_done)) begin
						fault      = 1'b1;
						fault_code = MD_UNEXPECTED;
					end else if (b_over || c_over) begin
						fault      = 1'b1;
						fault_code = MD_BADDATA;
					end else begin
						mode_n = MD_IDLE;
						frame  = 1'b1;
						status = ST_READY;
					end
				end
			end
			FN_SHUTDOWN: begin
				if (mode_q != MD_OFF) begin
					mode_n      = MD_OFF;
					done_mask_n = 2'b00;
					trig_n      = 2'b00;
				end
				status = ST_OFF;
			end
			default: status = mode_status(mode_q);
		endcase

		// first fault wins
		if (fault) begin
			trig_n = 2'b00;
			if (!mode_faulted(mode_q)) begin
				mode_n = fault_code;
			end
			status = mode_status(mode_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MD_OFF;
			enable_time_q   <= '0;
			arm_time_q      <= '0;
			held_deadline_q <= '0;
			done_mask_q     <= '0;
			trig_q          <= '0;
		end else if (step) begin
			mode_q          <= mode_n;
			enable_time_q   <= enable_time_n;
			arm_time_q      <= arm_time_n;
			held_deadline_q <= held_deadline_n;
			done_mask_q     <= done_mask_n;
			trig_q          <= trig_n;
		end
	end

	always_comb begin
		res.status           = status;
		res.frame_valid      = frame;
		res.b_value          = frame ? cmd.b_sample[VALUE_W-1:0] : '0;
		res.c_value          = frame ? cmd.c_sample[VALUE_W-1:0] : '0;
		res.arm_time_us      = frame ? arm_time_q : '0;
		res.done_time_us     = frame ? cmd.now_us : '0;
		res.b_trigger_enable = trig_n[0];
		res.c_trigger_enable = trig_n[1];
	end

`ifndef NO_ASSERTIONS
	a_frame_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && frame |=> mode_q == MD_IDLE)
		else $error("frame without return to idle");

	a_fault_latched: assert property (@(posedge clk) disable iff (!arst_n)
		mode_faulted(mode_q) && !(step && cmd.func == FN_SHUTDOWN) |=> mode_q == $past(mode_q))
		else $error("latched fault changed");

	a_trig_only_pending: assert property (@(posedge clk) disable iff (!arst_n)
		trig_q != 2'b00 |-> mode_q == MD_PENDING)
		else $error("trigger enabled outside pending");

	a_full_mask_not_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done_mask_q == 2'b11 |-> mode_q != MD_PENDING)
		else $error("both channels done but still pending");
`endif

endmodule

`default_nettype wire

FILE: rtl/dual_adc_capture_supervisor.sv
// ----------------------------------------------------------------------------
// dual_adc_capture_supervisor
// Supervisor for a two-channel triggered ADC capture: one result per command.
// ----------------------------------------------------------------------------
// Each command item (init, arm, take, shutdown) yields exactly one result
// item. An item is captured in an input register, decided by the combinational
// supervisor logic and held in a result register, so its result is offered
// once it has passed through both registers; one item can be accepted every
// clock while the result side is not stalled. A result left waiting holds the
// next command in the input register, so with the result side stalled one
// more command is taken and then the command side is held off until the
// result is accepted. Configuration is written through cfg_we/cfg_idx/cfg_wdata;
// the user must write it only while idle, as the block does not enforce this.
`default_nettype none

module dual_adc_capture_supervisor import dacs_pkg::*; #(
	parameter int unsigned WARMUP_US   = 10,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	dacs_cmd_if.sink                  cmd,
	dacs_res_if.source                res
);

	cfg_t cfg;
	logic valid_s1;
	cmd_t item_s1;
	logic advance;
	res_t res_comb;
	logic res_valid_q;
	res_t res_q;

	dacs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1 <= cmd.item;
		end
	end

	dacs_engine #(
		.WARMUP_US   (WARMUP_US),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.cmd    (item_s1),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_comb;
		end
	end

	assign res.valid = res_valid_q;
	assign res.item  = res_q;

endmodule

`default_nettype wire
